// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the SHA-256 stream hasher
// Controller states, command bundle, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned CntW       = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;       // shift one byte into the block register
    byte_sel_t sel;        // source of that byte
    logic [2:0] len_idx;   // length byte, most significant first
    logic      count;      // count one message byte
    logic      load_work;  // copy chaining words into working registers
    logic      round;      // run one compression round
    logic [5:0] rnd;       // round number
    logic      add;        // fold working registers into chaining words
    logic      init;       // restart for a new message
    logic [2:0] emit_idx;  // digest word on the output
  } cmd_t;

  localparam logic [7:0][31:0] InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hdl/sha_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if: valid/ready channels of the hasher
// Message byte channel and digest word channel.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer of the SHA-256 hasher
// Tracks block fill, padding progress, rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_byte_present,
  input  logic          in_end_of_message,
  output logic          out_valid,
  input  logic          out_ready,
  output sha_pkg::cmd_t cmd
);

  sha_pkg::state_t state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       ending_r, ending_nxt;
  logic       sent80_r, sent80_nxt;
  logic [3:0] len_r, len_nxt;
  logic [2:0] emit_r, emit_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha_pkg::ST_IDLE;
      fill_r   <= '0;
      rnd_r    <= '0;
      ending_r <= 1'b0;
      sent80_r <= 1'b0;
      len_r    <= '0;
      emit_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      ending_r <= ending_nxt;
      sent80_r <= sent80_nxt;
      len_r    <= len_nxt;
      emit_r   <= emit_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    ending_nxt = ending_r;
    sent80_nxt = sent80_r;
    len_nxt    = len_r;
    emit_nxt   = emit_r;
    cmd        = '0;
    cmd.sel    = sha_pkg::SEL_INPUT;
    cmd.len_idx = len_r[2:0];
    cmd.rnd    = rnd_r;
    cmd.emit_idx = emit_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ending_nxt = in_end_of_message;
          if (in_byte_present) begin
            cmd.push  = 1'b1;
            cmd.count = 1'b1;
            fill_nxt  = fill_r + 6'd1;
          end
          if (in_byte_present && fill_r == 6'(sha_pkg::BlockBytes - 1)) begin
            cmd.load_work = 1'b1;
            rnd_nxt   = '0;
            state_nxt = sha_pkg::ST_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        if (!sent80_r) begin
          cmd.sel    = sha_pkg::SEL_PAD80;
          sent80_nxt = 1'b1;
        end else if (len_r == 4'd0 && fill_r != 6'(sha_pkg::LenOffset)) begin
          cmd.sel = sha_pkg::SEL_ZERO;
        end else begin
          cmd.sel = sha_pkg::SEL_LEN;
          len_nxt = len_r + 4'd1;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'(sha_pkg::BlockBytes - 1)) begin
          cmd.load_work = 1'b1;
          rnd_nxt   = '0;
          state_nxt = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        if (!ending_r) begin
          state_nxt = sha_pkg::ST_IDLE;
        end else if (len_r == 4'd8) begin
          emit_nxt  = '0;
          state_nxt = sha_pkg::ST_EMIT;
        end else begin
          state_nxt = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          emit_nxt = emit_r + 3'd1;
          if (emit_r == 3'd7) begin
            cmd.init   = 1'b1;
            fill_nxt   = '0;
            ending_nxt = 1'b0;
            sent80_nxt = 1'b0;
            len_nxt    = '0;
            state_nxt  = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/sha_dp.sv =====
// ----------------------------------------------------------------------------
// sha_dp: datapath of the SHA-256 hasher
// Block shift register with message schedule, round unit, chaining words.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  sha_pkg::cmd_t cmd,
  input  logic [7:0]    in_data_byte,
  output logic [31:0]   out_digest_word
);

  logic [511:0]           blk_r;
  logic [7:0][31:0]       hash_r;
  logic [7:0][31:0]       work_r;
  logic [sha_pkg::CntW-1:0] count_r;
  logic [63:0]            bits;
  logic [7:0]             push_byte;
  logic [31:0]            w0, w1, w9, w14, w_new, s0, s1;
  logic [31:0]            a, b, c, d, e, f, g, h;
  logic [31:0]            t1, t2, big0, big1, ch, maj;

  assign bits = {count_r, 3'b000};

  // pick the byte to shift in
  always_comb begin
    unique case (cmd.sel)
      sha_pkg::SEL_INPUT: push_byte = in_data_byte;
      sha_pkg::SEL_PAD80: push_byte = 8'h80;
      sha_pkg::SEL_ZERO:  push_byte = 8'h00;
      sha_pkg::SEL_LEN:   push_byte = bits[8*(7 - cmd.len_idx) +: 8];
      default:            push_byte = 8'h00;
    endcase
  end

  // message schedule from the window of sixteen words
  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign s0  = sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  // one compression round
  assign {h, g, f, e, d, c, b, a} = work_r;
  assign big1 = sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25);
  assign ch   = (e & f) ^ (~e & g);
  assign t1   = h + big1 + ch + sha_pkg::RoundK[cmd.rnd] + w0;
  assign big0 = sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22);
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t2   = big0 + maj;

  // block register: shift bytes in, shift schedule words during rounds
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      work_r <= hash_r;
    end else if (cmd.round) begin
      work_r <= {g, f, e, d + t1, c, b, a, t1 + t2};
    end
  end

  // chaining words and byte count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      hash_r  <= sha_pkg::InitH;
      count_r <= '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + work_r[i];
        end
      end
      if (cmd.count) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign out_digest_word = hash_r[cmd.emit_idx];

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Hashes one message byte per transfer and returns the eight digest words.
//
//   channel   dir  payload                                   transfer when
//   in_ch     in   data_byte, byte_present, end_of_message   valid & ready
//   out_ch    out  digest_word, word_index, last_word        valid & ready
//
// The 64th byte of a block starts the compression rounds and the fold, during
// which in_ch is not ready. End of message pads one byte per cycle (up to 72
// bytes over at most two blocks, each block again followed by the rounds and
// the fold), then offers the eight digest words, one per cycle while out_ch
// is ready; in_ch stays not ready until the last word transfers.
// Reset is synchronous on rst_n; a stalled out_ch holds the current word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic clk,
  input  logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::cmd_t cmd;

  // sequencer
  sha_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_byte_present   (in_ch.byte_present),
    .in_end_of_message (in_ch.end_of_message),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .cmd               (cmd)
  );

  // datapath
  sha_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_ch.data_byte),
    .out_digest_word (out_ch.digest_word)
  );

  assign out_ch.word_index = cmd.emit_idx;
  assign out_ch.last_word  = (cmd.emit_idx == 3'd7);

endmodule

// ===== dv/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker: digest predictor and scoreboard of the hasher
// Watches both channels, hashes every accepted message byte on its own copy
// of the SHA-256 state and compares each digest word with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          mismatch_count,
  output int          words_pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t    digest_q[$];
  logic [31:0]     hash_words[8];
  logic [7:0]      block_bytes[64];
  int unsigned     block_fill;
  logic [60:0]     msg_bytes;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_words[i] = sha_pkg::InitH[i];
    block_fill = 0;
    msg_bytes  = '0;
  endtask

  // Run the 64 rounds over the buffered block and fold into the hash words
  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + sha_pkg::RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endtask

  task automatic append_byte(input logic [7:0] value);
    block_bytes[block_fill] = value;
    block_fill++;
    if (block_fill == sha_pkg::BlockBytes) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  // Pad, encode the bit length and queue the eight digest words
  task automatic finish_message();
    logic [63:0] bit_len;
    bit_len = {msg_bytes, 3'b000};
    append_byte(8'h80);
    while (block_fill != sha_pkg::LenOffset) append_byte(8'h00);
    for (int i = 7; i >= 0; i--) append_byte(bit_len[8*i +: 8]);
    for (int i = 0; i < 8; i++)
      digest_q.insert(digest_q.size(),
                      digest_word_t'{word: hash_words[i], index: 3'(i), last: (i == 7)});
    restart_message();
  endtask

  initial begin
    mismatch_count = 0;
    restart_message();
  end

  assign words_pending = digest_q.size();

  // Sample at the falling edge; the transfer happens at the next rising edge
  always @(negedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_byte_present) begin
          msg_bytes = msg_bytes + 61'd1;
          append_byte(in_data_byte);
        end
        if (in_end_of_message) finish_message();
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word %h index %0d last %0b",
                     out_digest_word, out_word_index, out_last_word);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_word !== exp_w.word || out_word_index !== exp_w.index ||
              out_last_word !== exp_w.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                       exp_w.word, exp_w.index, exp_w.last,
                       out_digest_word, out_word_index, out_last_word);
          end
        end
      end
    end
  end

endmodule

// ===== dv/sha256_stream_hasher_test.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test: regression bench of the SHA-256 stream hasher
// Sends directed and random messages with random idle gaps on both channels,
// including one long result stall, and lets the checker score the digests.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;

  localparam int IdleLimit = 3000;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   words_pending;
  int   words_taken;
  int   idle_cycles;
  int   items_sent;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha256_digest_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data_byte),
    .in_byte_present   (in_ch.byte_present),
    .in_end_of_message (in_ch.end_of_message),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_digest_word   (out_ch.digest_word),
    .out_word_index    (out_ch.word_index),
    .out_last_word     (out_ch.last_word),
    .mismatch_count    (mismatch_count),
    .words_pending     (words_pending)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic [7:0] value, input logic present,
                           input logic last, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= value;
    in_ch.byte_present   <= present;
    in_ch.end_of_message <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int len, input bit end_with_byte, input bit no_gaps);
    for (int i = 0; i < len; i++) begin
      if (!no_gaps && $urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, no_gaps);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1), no_gaps);
    end
    if (!end_with_byte || len == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, no_gaps);
  endtask

  // Receiver: random ready with one long hold-off while the sender keeps going
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && words_taken >= 16) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (gap_len() > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      words_taken <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
      if (out_ch.valid && out_ch.ready) words_taken <= words_taken + 1;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    items_sent = 0;
    rst_n <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= 8'h00;
    in_ch.byte_present   <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, single bytes at both extremes, byte with end,
    // ignored items inside a message, a separate end mark
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
    send_item(8'ha5, 1'b0, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1, 1'b0);
    send_message(1, 1'b0, 1'b1);

    // Random messages, mostly short, some across block and padding borders
    while (items_sent < 165) begin
      r = $urandom_range(0, 99);
      if (r < 65)      send_message($urandom_range(0, 20), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 3) == 0);
      else if (r < 90) send_message($urandom_range(54, 65), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 3) == 0);
      else             send_message($urandom_range(110, 130), 1'($urandom_range(0, 1)),
                                    1'b0);
    end
    in_ch.valid <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
